// ===== sv/ipms_pkg.sv =====
// ----------------------------------------------------------------------------
// ipms_pkg
// Types and constants shared by the incremental PI motor speed controller.
// ----------------------------------------------------------------------------
package ipms_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TARGET_SPEED  = 2'd0;
    localparam logic [1:0] REG_PROP_GAIN     = 2'd1;
    localparam logic [1:0] REG_INTEGRAL_GAIN = 2'd2;
    localparam logic [1:0] REG_DRIVE_LIMIT   = 2'd3;

    // Reset values of the configuration registers
    localparam logic signed [15:0] TARGET_SPEED_RST  = 16'sd3;
    localparam logic [15:0]        PROP_GAIN_RST     = 16'd100;
    localparam logic [15:0]        INTEGRAL_GAIN_RST = 16'd100;
    localparam logic [14:0]        DRIVE_LIMIT_RST   = 15'd7100;

    localparam int ERR_W  = 17;   // count - target
    localparam int DERR_W = 18;   // error - previous error
    localparam int ACC_W  = 32;
    localparam int SUM_W  = 37;   // headroom for acc + two products

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [DERR_W-1:0] derr_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic [14:0]        magnitude;
        logic               forward;
    } drive_t;

endpackage

// ===== sv/ipms_update.sv =====
// ----------------------------------------------------------------------------
// ipms_update
// Error, incremental PI accumulate with saturation, and the controller state.
// ----------------------------------------------------------------------------
module ipms_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic signed [15:0]  encoder_count,
    input  logic signed [15:0]  target_speed,
    input  logic [15:0]         prop_gain,
    input  logic [15:0]         integral_gain,
    output ipms_pkg::acc_t      acc_next
);
    import ipms_pkg::*;

    acc_t  acc_reg;
    derr_t prev_err_reg;
    derr_t prev_err_next;

    err_t                   err;
    derr_t                  derr;
    logic signed [34:0]     p_term;
    logic signed [33:0]     i_term;
    sum_t                   sum;
    logic                   sat_hi;
    logic                   sat_lo;

    assign err  = ERR_W'(encoder_count) - ERR_W'(target_speed);
    assign derr = DERR_W'(err) - prev_err_reg;

    assign p_term = $signed({1'b0, prop_gain}) * derr;
    assign i_term = $signed({1'b0, integral_gain}) * err;

    assign sum = SUM_W'(acc_reg) + SUM_W'(p_term) + SUM_W'(i_term);

    // Saturate to the signed 32-bit range when the upper bits disagree
    assign sat_hi = !sum[SUM_W-1] && (sum[SUM_W-2:ACC_W-1] != '0);
    assign sat_lo =  sum[SUM_W-1] && (sum[SUM_W-2:ACC_W-1] != '1);

    always_comb begin
        if (sat_hi) begin
            acc_next = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (sat_lo) begin
            acc_next = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    assign prev_err_next = DERR_W'(err);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            prev_err_reg <= '0;
        end else if (en) begin
            acc_reg      <= acc_next;
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

// ===== sv/ipms_clamp.sv =====
// ----------------------------------------------------------------------------
// ipms_clamp
// Clamp the accumulator to the drive limit; form magnitude and direction.
// ----------------------------------------------------------------------------
module ipms_clamp (
    input  ipms_pkg::acc_t   acc,
    input  logic [14:0]      drive_limit,
    output ipms_pkg::drive_t drive
);
    import ipms_pkg::*;

    acc_t               lim_pos;
    acc_t               lim_neg;
    logic signed [15:0] drv;

    assign lim_pos = $signed({{(ACC_W-15){1'b0}}, drive_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (acc > lim_pos) begin
            drv = lim_pos[15:0];
        end else if (acc < lim_neg) begin
            drv = lim_neg[15:0];
        end else begin
            drv = acc[15:0];
        end
    end

    always_comb begin
        drive.value     = drv;
        drive.magnitude = drv[15] ? 15'(-drv) : drv[14:0];
        drive.forward   = !drv[15] && (drv != '0);
    end

endmodule

// ===== sv/incremental_pi_motor_speed.sv =====
// ----------------------------------------------------------------------------
// incremental_pi_motor_speed
// An item passes through the input register, then the result register,
// before its result is valid on the result channel.
// Throughput: one item per cycle while m_ready stays high; the accumulate
// path between the two registers bounds the clock. Synchronous active-low
// reset clears the accumulator, previous error and both valid flags, and
// loads the configuration defaults (target 3, gains 100, limit 7100).
// ----------------------------------------------------------------------------
module incremental_pi_motor_speed (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_encoder_count,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_drive_value,
    output logic [14:0]        m_drive_magnitude,
    output logic               m_direction_forward
);
    import ipms_pkg::*;

    logic signed [15:0] target_speed_reg;
    logic [15:0]        prop_gain_reg;
    logic [15:0]        integral_gain_reg;
    logic [14:0]        drive_limit_reg;

    logic               in_valid_reg;
    logic signed [15:0] in_count_reg;
    logic               out_valid_reg;
    drive_t             out_reg;

    logic   advance;
    logic   fire;
    acc_t   acc_next;
    drive_t drive;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_speed_reg  <= TARGET_SPEED_RST;
            prop_gain_reg     <= PROP_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            drive_limit_reg   <= DRIVE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_SPEED:  target_speed_reg  <= $signed(cfg_wdata);
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata;
                REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_wdata;
                REG_DRIVE_LIMIT:   drive_limit_reg   <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Result register frees when empty or taken; input register frees when
    // empty or when its item moves on.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_count_reg <= s_encoder_count;
        end
    end

    ipms_update u_update (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (fire),
        .encoder_count (in_count_reg),
        .target_speed  (target_speed_reg),
        .prop_gain     (prop_gain_reg),
        .integral_gain (integral_gain_reg),
        .acc_next      (acc_next)
    );

    ipms_clamp u_clamp (
        .acc         (acc_next),
        .drive_limit (drive_limit_reg),
        .drive       (drive)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= drive;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_drive_value       = out_reg.value;
    assign m_drive_magnitude   = out_reg.magnitude;
    assign m_direction_forward = out_reg.forward;

    a_mag_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.magnitude <= drive_limit_reg))
        else $error("drive magnitude exceeds limit");

    a_mag_matches_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_reg.value == $signed({1'b0, out_reg.magnitude}))
                        || (out_reg.value == -$signed({1'b0, out_reg.magnitude}))))
        else $error("drive magnitude does not match drive value");

    a_forward_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.forward == (out_reg.value > 16'sd0)))
        else $error("direction bit disagrees with drive sign");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while pipeline has room");

endmodule
